// File: design/cmef_pkg.sv
// Shared types and constants for the clamp, median and moving average filter.
package cmef_pkg;

    // Sample, weight and average widths.
    localparam int SAMPLE_W = 16;
    localparam int WEIGHT_W = 17;
    localparam int AVG_W    = 24;

    // Age of a window entry; four bits cover windows of up to sixteen entries.
    localparam int AGE_W = 4;

    // Unity weight in Q1.16.
    localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = 17'h10000;

    // Configuration register indexes.
    localparam int CFG_INDEX_W = 2;
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_CLAMP_LOW  = 2'd0,
        CFG_CLAMP_HIGH = 2'd1,
        CFG_WEIGHT     = 2'd2
    } t_cfg_index;

    // What one sorting cell hands to a neighbor: a value, its age and whether
    // it is a live entry that sorts at or below the incoming sample.
    typedef struct packed {
        logic [SAMPLE_W-1:0] value;
        logic [AGE_W-1:0]    age;
        logic                le;
    } t_link;

endpackage

// File: design/cmef_cell.sv
// One cell of the sorted window chain: holds one entry and its age.
module cmef_cell #(
    parameter int WINDOW_LEN = 5
) (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  logic [cmef_pkg::SAMPLE_W-1:0] i_sample,
    input  cmef_pkg::t_link               i_up,
    input  cmef_pkg::t_link               i_down_rem,
    input  logic                          i_dl,
    output cmef_pkg::t_link               o_raw,
    output cmef_pkg::t_link               o_rem,
    output logic                          o_dl,
    output logic [cmef_pkg::SAMPLE_W-1:0] o_value
);

    logic [cmef_pkg::SAMPLE_W-1:0] r_value;
    logic [cmef_pkg::AGE_W-1:0]    r_age;
    logic [cmef_pkg::SAMPLE_W-1:0] n_value;
    logic [cmef_pkg::AGE_W-1:0]    n_age;
    logic                          w_del;

    // The oldest entry leaves the window once it is full.
    assign w_del = i_valid && (r_age == cmef_pkg::AGE_W'(WINDOW_LEN - 1));

    // Own entry as seen by neighbors.
    always_comb begin
        o_raw.value = r_value;
        o_raw.age   = r_age;
        o_raw.le    = i_valid && ($signed(r_value) <= $signed(i_sample));
    end

    // Deletion marker ripples upward; at or above it every entry moves down.
    assign o_dl  = i_dl || w_del;
    assign o_rem = o_dl ? i_up : o_raw;

    // Insert the sample above all remaining entries that sort at or below it.
    always_comb begin
        if (o_rem.le) begin
            n_value = o_rem.value;
            n_age   = o_rem.age + 1'b1;
        end else if (i_down_rem.le) begin
            n_value = i_sample;
            n_age   = '0;
        end else begin
            n_value = i_down_rem.value;
            n_age   = i_down_rem.age + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_value <= n_value;
            r_age   <= n_age;
        end
    end

    assign o_value = r_value;

endmodule

// File: design/cmef_ema.sv
// Moving average update: one product stage, then the sum and the accumulator.
module cmef_ema (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_load,
    input  logic                          i_commit,
    input  logic [cmef_pkg::SAMPLE_W-1:0] i_median,
    input  logic                          i_first,
    input  logic [cmef_pkg::WEIGHT_W-1:0] i_weight,
    output logic [cmef_pkg::SAMPLE_W-1:0] o_median,
    output logic [cmef_pkg::AVG_W-1:0]    o_acc_next
);

    localparam int P1_W  = cmef_pkg::WEIGHT_W + 1 + cmef_pkg::SAMPLE_W;
    localparam int P2_W  = cmef_pkg::WEIGHT_W + 1 + cmef_pkg::AVG_W;
    localparam int SUM_W = P2_W + 2;

    logic signed [P1_W-1:0]          r_p1;
    logic signed [P2_W-1:0]          r_p2;
    logic                            r_first;
    logic [cmef_pkg::SAMPLE_W-1:0]   r_med;
    logic [cmef_pkg::AVG_W-1:0]      r_acc;
    logic [cmef_pkg::WEIGHT_W-1:0]   w_weight;
    logic [cmef_pkg::WEIGHT_W-1:0]   w_inv;
    logic signed [SUM_W-1:0]         w_sum;

    // Weights above one saturate to one.
    assign w_weight = (i_weight > cmef_pkg::WEIGHT_ONE) ? cmef_pkg::WEIGHT_ONE : i_weight;
    assign w_inv    = cmef_pkg::WEIGHT_ONE - w_weight;

    // Both products from the median and the current average.
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_p1    <= $signed({1'b0, w_weight}) * $signed(i_median);
            r_p2    <= $signed({1'b0, w_inv}) * $signed(r_acc);
            r_first <= i_first;
            r_med   <= i_median;
        end
    end

    // Weighted sum, floored by dropping sixteen fraction bits.
    assign w_sum      = (SUM_W'(r_p1) <<< 8) + SUM_W'(r_p2);
    assign o_acc_next = r_first ? {r_med, 8'h00} : w_sum[cmef_pkg::AVG_W+15:16];
    assign o_median   = r_med;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
        end else if (i_commit) begin
            r_acc <= o_acc_next;
        end
    end

endmodule

// File: design/clamp_median_ema_filter.sv
// Each sample beat passes through stage A, stage B and the output register; a
// new sample beat is not taken while stage A still holds one, as the average
// feedback path runs through the registered product stage.
// Reset (synchronous, active low) empties the window, clears the average and
// loads the register reset values; no clearing pass is needed.
module clamp_median_ema_filter #(
    parameter int WINDOW_LEN = 5
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Input stream.
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    input  logic [15:0]                         i_s_tdata,  // raw_sample
    // Output stream.
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    // clamped_sample [15:0], median_sample [31:16], smoothed_value [55:32]
    output logic [55:0]                         o_m_tdata,
    // Configuration writes.
    input  logic                                i_cfg_wr_en,
    input  logic [cmef_pkg::CFG_INDEX_W-1:0]    i_cfg_index,
    input  logic [cmef_pkg::WEIGHT_W-1:0]       i_cfg_data
);

    localparam int FILL_W = $clog2(WINDOW_LEN + 1);
    localparam int SW     = cmef_pkg::SAMPLE_W;

    logic [SW-1:0]                 r_clamp_low;
    logic [SW-1:0]                 r_clamp_high;
    logic [cmef_pkg::WEIGHT_W-1:0] r_weight;
    logic [FILL_W-1:0]             r_fill;
    logic                          r_a_valid;
    logic                          r_b_valid;
    logic [SW-1:0]                 r_a_clamp;
    logic [SW-1:0]                 r_b_clamp;
    logic                          r_out_valid;
    logic [55:0]                   r_out_data;

    logic                          w_accept;
    logic                          w_out_free;
    logic                          w_a_to_b;
    logic                          w_b_done;
    logic [SW-1:0]                 w_clamp;
    logic [SW-1:0]                 w_median;
    logic [FILL_W-1:0]             w_mid;
    logic [SW-1:0]                 w_ema_med;
    logic [cmef_pkg::AVG_W-1:0]    w_acc_next;

    cmef_pkg::t_link               w_raw    [WINDOW_LEN];
    cmef_pkg::t_link               w_rem    [WINDOW_LEN];
    cmef_pkg::t_link               w_up     [WINDOW_LEN];
    cmef_pkg::t_link               w_down   [WINDOW_LEN];
    logic                          w_dl     [WINDOW_LEN];
    logic                          w_dl_in  [WINDOW_LEN];
    logic [SW-1:0]                 w_value  [WINDOW_LEN];

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clamp_low  <= 16'h8000;
            r_clamp_high <= 16'h7FFF;
            r_weight     <= 17'h08000;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                cmef_pkg::CFG_CLAMP_LOW:  r_clamp_low  <= i_cfg_data[SW-1:0];
                cmef_pkg::CFG_CLAMP_HIGH: r_clamp_high <= i_cfg_data[SW-1:0];
                cmef_pkg::CFG_WEIGHT:     r_weight     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Handshake and stage movement.
    assign w_out_free = !r_out_valid || i_m_tready;
    assign w_b_done   = r_b_valid && w_out_free;
    assign w_a_to_b   = r_a_valid && (!r_b_valid || w_out_free);
    assign o_s_tready = !r_a_valid && (!r_b_valid || w_out_free);
    assign w_accept   = i_s_tvalid && o_s_tready;

    // Raise to the low limit first, then lower to the high limit.
    always_comb begin
        w_clamp = i_s_tdata;
        if ($signed(w_clamp) < $signed(r_clamp_low)) begin
            w_clamp = r_clamp_low;
        end
        if ($signed(w_clamp) > $signed(r_clamp_high)) begin
            w_clamp = r_clamp_high;
        end
    end

    // Sorted window chain.
    genvar j;
    generate
        for (j = 0; j < WINDOW_LEN; j++) begin : g_cell
            if (j == 0) begin : g_bottom
                assign w_down[j]  = '{value: '0, age: '0, le: 1'b1};
                assign w_dl_in[j] = 1'b0;
            end else begin : g_inner
                assign w_down[j]  = w_rem[j-1];
                assign w_dl_in[j] = w_dl[j-1];
            end
            if (j == WINDOW_LEN - 1) begin : g_top
                assign w_up[j] = '{value: '0, age: '0, le: 1'b0};
            end else begin : g_below
                assign w_up[j] = w_raw[j+1];
            end

            cmef_cell #(
                .WINDOW_LEN (WINDOW_LEN)
            ) u_cell (
                .i_clk      (i_clk),
                .i_en       (w_accept),
                .i_valid    (FILL_W'(j) < r_fill),
                .i_sample   (w_clamp),
                .i_up       (w_up[j]),
                .i_down_rem (w_down[j]),
                .i_dl       (w_dl_in[j]),
                .o_raw      (w_raw[j]),
                .o_rem      (w_rem[j]),
                .o_dl       (w_dl[j]),
                .o_value    (w_value[j])
            );
        end
    endgenerate

    // Fill count saturates at the window length.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else if (w_accept && (r_fill != FILL_W'(WINDOW_LEN))) begin
            r_fill <= r_fill + 1'b1;
        end
    end

    // Median is the middle cell of the filled part.
    assign w_mid = r_fill >> 1;
    always_comb begin
        w_median = '0;
        for (int k = 0; k < WINDOW_LEN; k++) begin
            if (FILL_W'(k) == w_mid) begin
                w_median = w_value[k];
            end
        end
    end

    // Stage valid flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid   <= 1'b0;
            r_b_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_a_valid <= 1'b1;
            end else if (w_a_to_b) begin
                r_a_valid <= 1'b0;
            end
            if (w_a_to_b) begin
                r_b_valid <= 1'b1;
            end else if (w_b_done) begin
                r_b_valid <= 1'b0;
            end
            if (w_b_done) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Clamped sample travels with its item.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_a_clamp <= w_clamp;
        end
        if (w_a_to_b) begin
            r_b_clamp <= r_a_clamp;
        end
    end

    cmef_ema u_ema (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (w_a_to_b),
        .i_commit   (w_b_done),
        .i_median   (w_median),
        .i_first    (r_fill == FILL_W'(1)),
        .i_weight   (r_weight),
        .o_median   (w_ema_med),
        .o_acc_next (w_acc_next)
    );

    // Output register.
    always_ff @(posedge i_clk) begin
        if (w_b_done) begin
            r_out_data <= {w_acc_next, w_ema_med, r_b_clamp};
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

`ifndef SYNTHESIS
    // Two sample beats are never taken in back-to-back cycles.
    a_no_consecutive_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> !w_accept)
        else $error("sample beats accepted in consecutive cycles");

    // The fill count never passes the window length.
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FILL_W'(WINDOW_LEN))
        else $error("fill count beyond window length");

    // A full window stays full.
    a_fill_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fill == FILL_W'(WINDOW_LEN)) |=> (r_fill == FILL_W'(WINDOW_LEN)))
        else $error("full window lost an entry");

    // A stalled result beat keeps its data.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_m_tready) |=> (r_out_valid && $stable(r_out_data)))
        else $error("result beat changed while stalled");
`endif

endmodule
